>>> hdl/sfsfeq_pkg.sv
// shared constants, payload types, state codes and saturation helpers
// for the stereo five-band slew filter equalizer; no dependencies
package sfsfeq_pkg;

    // number of split-and-sum passes, each with its own filter state
    localparam int PASSES = 2;

    localparam int NUM_SECTIONS = 5;
    localparam int NUM_GAINS = 6;
    localparam int SAMPLE_W = 24;
    localparam int WORD_W = 32;
    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

    // one memory row holds pos (low word) and slew (high word) of one section
    localparam int ROWS = NUM_SECTIONS * 2 * PASSES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int RAM_W = 2 * WORD_W;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int SEC_W = $clog2(NUM_SECTIONS);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);
    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

    // shared multiplier operand and result widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 24;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = 52;

    // apb register port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = $clog2(NUM_GAINS * 4);
    localparam int RIDX_W = PADDR_W - 2;

    // Q0.24 section coefficients
    localparam logic signed [MUL_B_W-1:0] SECTION_COEF [NUM_SECTIONS] = '{
        24'sd4367431, 24'sd2393698, 24'sd679021, 24'sd203971, 24'sd86395
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_t;

    typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] gain_array_t;

    typedef enum logic [RIDX_W-1:0] {
        REG_TOP_BAND    = 3'd0,
        REG_BAND_ONE    = 3'd1,
        REG_BAND_TWO    = 3'd2,
        REG_BAND_THREE  = 3'd3,
        REG_BAND_FOUR   = 3'd4,
        REG_BOTTOM_BAND = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLEW,
        ST_POS,
        ST_WRITE,
        ST_BAND,
        ST_BOTTOM,
        ST_TAIL,
        ST_SUM,
        ST_DONE
    } state_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 40'sh007FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sh0080000000)
            r = 32'sh80000000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [WORD_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 32'sh007FFFFF)
            r = 24'sh7FFFFF;
        else if (v < -32'sh00800000)
            r = 24'sh800000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/stereo_five_band_slew_filter_eq_core.sv
// top level of the stereo five-band slew filter equalizer: sequencer, shared multiplier
// datapath and filter state memory; depends on sfsfeq_pkg, sfsfeq_ram, sfsfeq_regs
//
//   port group   direction  payload            transaction when
//   in_*         in         sfsfeq_pkg::in_t   in_valid && in_ready
//   out_*        out        sfsfeq_pkg::out_t  out_valid && out_ready
//   apb (p*)     in/out     six gain regs      psel && penable && pwrite (write)
//
// for each item, each filter section of each pass and channel uses the
// single multiplier three times (slew, position, band weight) plus a memory write state.
// in_ready is high only while idle; a finished pair waits in the output register and the
// next item is taken meanwhile, but the block holds its result until that slot frees up.
// reset clears control state and row valid bits, gains go to unity; needs no clearing pass.
module stereo_five_band_slew_filter_eq_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfsfeq_pkg::PADDR_W-1:0]     paddr,
    input  logic [sfsfeq_pkg::PDATA_W-1:0]     pwdata,
    output logic [sfsfeq_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sfsfeq_pkg::in_t                    in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sfsfeq_pkg::out_t                   out_data
);

    localparam int W = sfsfeq_pkg::WORD_W;

    sfsfeq_pkg::gain_array_t gains;
    sfsfeq_pkg::state_t      state_reg, state_next;

    logic [sfsfeq_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic [sfsfeq_pkg::SEC_W-1:0]  sec_reg, sec_next;
    logic                          ch_reg, ch_next;

    logic signed [sfsfeq_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [W:0]                    ps_reg, ps_next;
    logic signed [W-1:0]                  slew_reg, slew_next;
    logic signed [W-1:0]                  low_reg, low_next;
    logic signed [W-1:0]                  x_reg, x_next;
    logic signed [sfsfeq_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                                 acc_pend_reg, acc_pend_next;
    logic signed [sfsfeq_pkg::SAMPLE_W-1:0] right_hold_reg, right_hold_next;
    logic signed [sfsfeq_pkg::SAMPLE_W-1:0] left_res_reg, left_res_next;
    sfsfeq_pkg::out_t                     out_data_reg, out_data_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [sfsfeq_pkg::ROWS-1:0] valid_reg, valid_next;
    logic [sfsfeq_pkg::ROW_W-1:0] rd_row_reg;
    logic [sfsfeq_pkg::ROW_W-1:0] raddr, waddr;
    logic                         we;
    logic [sfsfeq_pkg::RAM_W-1:0] wdata, rdata;

    logic signed [sfsfeq_pkg::MUL_A_W-1:0] mul_a;
    logic signed [sfsfeq_pkg::MUL_B_W-1:0] mul_b;
    logic signed [sfsfeq_pkg::PROD_W-1:0]  mul_p;

    logic signed [W-1:0]                  mem_pos, mem_slew;
    logic signed [sfsfeq_pkg::PROD_W-1:0] rnd_slew, rnd_pos;
    logic signed [sfsfeq_pkg::ACC_W-1:0]  rnd_acc;
    logic signed [W:0]                    slew_sh;
    logic signed [W+1:0]                  pos_sh;
    logic signed [W+2:0]                  low_sum;
    logic signed [W+5:0]                  acc_sh;
    logic signed [W-1:0]                  low_calc, pass_val;
    logic                                 out_free;
    logic [sfsfeq_pkg::GAIN_W-1:0]        band_gain;

    sfsfeq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    sfsfeq_ram #(
        .WIDTH (sfsfeq_pkg::RAM_W),
        .DEPTH (sfsfeq_pkg::ROWS)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // read address always points at the row that the next cycle's counters select
    assign raddr = sfsfeq_pkg::ROW_W'((pass_next * (2 * sfsfeq_pkg::NUM_SECTIONS))
                                      + (sec_next * 2) + ch_next);
    assign waddr = sfsfeq_pkg::ROW_W'((pass_reg * (2 * sfsfeq_pkg::NUM_SECTIONS))
                                      + (sec_reg * 2) + ch_reg);

    // a row never written since reset reads as zero
    assign mem_pos  = valid_reg[rd_row_reg] ? $signed(rdata[W-1:0]) : '0;
    assign mem_slew = valid_reg[rd_row_reg] ? $signed(rdata[2*W-1:W]) : '0;

    assign mul_p = mul_a * mul_b;

    assign rnd_slew = prod_reg + sfsfeq_pkg::PROD_W'(64'sd16777216);
    assign slew_sh  = $signed(rnd_slew[sfsfeq_pkg::PROD_W-1:25]);
    assign rnd_pos  = prod_reg + sfsfeq_pkg::PROD_W'(64'sd8388608);
    assign pos_sh   = $signed(rnd_pos[sfsfeq_pkg::PROD_W-1:24]);
    assign low_sum  = (W+3)'(ps_reg) + (W+3)'(pos_sh);
    assign low_calc = sfsfeq_pkg::sat32(40'(low_sum));
    assign rnd_acc  = acc_reg + sfsfeq_pkg::ACC_W'(64'sd8192);
    assign acc_sh   = $signed(rnd_acc[sfsfeq_pkg::ACC_W-1:14]);
    assign pass_val = sfsfeq_pkg::sat32(40'(acc_sh));
    assign band_gain = gains[sec_reg];

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfsfeq_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = sfsfeq_pkg::ST_SLEW;
            end
            sfsfeq_pkg::ST_SLEW:   state_next = sfsfeq_pkg::ST_POS;
            sfsfeq_pkg::ST_POS:    state_next = sfsfeq_pkg::ST_WRITE;
            sfsfeq_pkg::ST_WRITE:  state_next = sfsfeq_pkg::ST_BAND;
            sfsfeq_pkg::ST_BAND:
            begin
                if (sec_reg == sfsfeq_pkg::LAST_SEC)
                    state_next = sfsfeq_pkg::ST_BOTTOM;
                else
                    state_next = sfsfeq_pkg::ST_SLEW;
            end
            sfsfeq_pkg::ST_BOTTOM: state_next = sfsfeq_pkg::ST_TAIL;
            sfsfeq_pkg::ST_TAIL:   state_next = sfsfeq_pkg::ST_SUM;
            sfsfeq_pkg::ST_SUM:
            begin
                if (pass_reg == sfsfeq_pkg::LAST_PASS && ch_reg)
                    state_next = sfsfeq_pkg::ST_DONE;
                else
                    state_next = sfsfeq_pkg::ST_SLEW;
            end
            sfsfeq_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = sfsfeq_pkg::ST_IDLE;
            end
            default:               state_next = sfsfeq_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pass_next       = pass_reg;
        sec_next        = sec_reg;
        ch_next         = ch_reg;
        prod_next       = prod_reg;
        ps_next         = ps_reg;
        slew_next       = slew_reg;
        low_next        = low_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        acc_pend_next   = 1'b0;
        right_hold_next = right_hold_reg;
        left_res_next   = left_res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        valid_next      = valid_reg;
        we              = 1'b0;
        wdata           = {slew_reg, low_calc};
        mul_a           = (sfsfeq_pkg::MUL_A_W)'(x_reg) - (sfsfeq_pkg::MUL_A_W)'(low_reg);
        mul_b           = $signed({{(sfsfeq_pkg::MUL_B_W - sfsfeq_pkg::GAIN_W){1'b0}},
                                   band_gain});
        in_ready        = 1'b0;

        // band products are registered and added to the accumulator in the following cycle
        if (acc_pend_reg)
            acc_next = acc_reg + prod_reg[sfsfeq_pkg::ACC_W-1:0];

        unique case (state_reg)
            sfsfeq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x_next = $signed({{(W - sfsfeq_pkg::SAMPLE_W){in_data.left_sample[23]}},
                                      in_data.left_sample});
                    right_hold_next = in_data.right_sample;
                end
            end
            sfsfeq_pkg::ST_SLEW:
            begin
                mul_a = (sfsfeq_pkg::MUL_A_W)'(x_reg) - (sfsfeq_pkg::MUL_A_W)'(mem_pos)
                        + (sfsfeq_pkg::MUL_A_W)'(mem_slew);
                mul_b = sfsfeq_pkg::SECTION_COEF[sec_reg];
                prod_next = mul_p;
                ps_next = (W+1)'(mem_pos) + (W+1)'(mem_slew);
            end
            sfsfeq_pkg::ST_POS:
            begin
                // f*v + (1-f)*(pos+slew) regrouped as (pos+slew) + f*(v-pos-slew)
                mul_a = (sfsfeq_pkg::MUL_A_W)'(x_reg) - (sfsfeq_pkg::MUL_A_W)'(ps_reg);
                mul_b = sfsfeq_pkg::SECTION_COEF[sec_reg];
                prod_next = mul_p;
                slew_next = sfsfeq_pkg::sat32(40'(slew_sh));
            end
            sfsfeq_pkg::ST_WRITE:
            begin
                we = 1'b1;
                valid_next[waddr] = 1'b1;
                low_next = low_calc;
            end
            sfsfeq_pkg::ST_BAND:
            begin
                // (upper input - this lowpass) * gain of this band
                prod_next = mul_p;
                acc_pend_next = 1'b1;
                x_next = low_reg;
                if (sec_reg != sfsfeq_pkg::LAST_SEC)
                    sec_next = sec_reg + 1'b1;
            end
            sfsfeq_pkg::ST_BOTTOM:
            begin
                mul_a = (sfsfeq_pkg::MUL_A_W)'(x_reg);
                mul_b = $signed({{(sfsfeq_pkg::MUL_B_W - sfsfeq_pkg::GAIN_W){1'b0}},
                                 gains[sfsfeq_pkg::NUM_GAINS-1]});
                prod_next = mul_p;
                acc_pend_next = 1'b1;
            end
            sfsfeq_pkg::ST_TAIL:
            begin
                acc_pend_next = 1'b0;
            end
            sfsfeq_pkg::ST_SUM:
            begin
                acc_next = '0;
                sec_next = '0;
                x_next = pass_val;
                if (pass_reg != sfsfeq_pkg::LAST_PASS)
                begin
                    pass_next = pass_reg + 1'b1;
                end
                else if (!ch_reg)
                begin
                    left_res_next = sfsfeq_pkg::sat24(pass_val);
                    pass_next = '0;
                    ch_next = 1'b1;
                    x_next = $signed({{(W - sfsfeq_pkg::SAMPLE_W){right_hold_reg[23]}},
                                      right_hold_reg});
                end
            end
            sfsfeq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.left_out = left_res_reg;
                    out_data_next.right_out = sfsfeq_pkg::sat24(x_reg);
                    out_valid_next = 1'b1;
                    pass_next = '0;
                    sec_next = '0;
                    ch_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfsfeq_pkg::ST_IDLE;
            pass_reg      <= '0;
            sec_reg       <= '0;
            ch_reg        <= 1'b0;
            acc_reg       <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            sec_reg       <= sec_next;
            ch_reg        <= ch_next;
            acc_reg       <= acc_next;
            acc_pend_reg  <= acc_pend_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        ps_reg         <= ps_next;
        slew_reg       <= slew_next;
        low_reg        <= low_next;
        x_reg          <= x_next;
        right_hold_reg <= right_hold_next;
        left_res_reg   <= left_res_next;
        out_data_reg   <= out_data_next;
        rd_row_reg     <= raddr;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_starts_section: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == sfsfeq_pkg::ST_SLEW && sec_reg == '0
                                 && pass_reg == '0 && !ch_reg)
        else $error("item did not start at the first section of the left channel");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sfsfeq_pkg::ST_DONE |-> ch_reg && pass_reg == sfsfeq_pkg::LAST_PASS)
        else $error("result reached before the last pass of the right channel");

    a_acc_clear_at_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sfsfeq_pkg::ST_SLEW && sec_reg == '0 |-> acc_reg == '0 && !acc_pend_reg)
        else $error("band accumulator not clear at the start of a pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == sfsfeq_pkg::ST_DONE))
        else $error("result presented outside of the completion step");

    a_section_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= sfsfeq_pkg::LAST_SEC && (!we || state_reg == sfsfeq_pkg::ST_WRITE))
        else $error("section counter out of range or stray state write");

endmodule

>>> hdl/sfsfeq_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module sfsfeq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sfsfeq_regs.sv
// apb register file holding the six Q1.14 band gains
// depends on sfsfeq_pkg
module sfsfeq_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfsfeq_pkg::PADDR_W-1:0]      paddr,
    input  logic [sfsfeq_pkg::PDATA_W-1:0]      pwdata,
    output logic [sfsfeq_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready,
    output sfsfeq_pkg::gain_array_t             gains
);

    sfsfeq_pkg::gain_array_t gains_reg;
    sfsfeq_pkg::gain_array_t gains_next;
    sfsfeq_pkg::reg_index_t  idx;
    logic                    wr_en;
    logic [sfsfeq_pkg::GAIN_W-1:0] wval;
    logic [sfsfeq_pkg::GAIN_W-1:0] rval;

    assign idx = sfsfeq_pkg::reg_index_t'(paddr[sfsfeq_pkg::PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign wval = pwdata[sfsfeq_pkg::GAIN_W-1:0];

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (idx)
                sfsfeq_pkg::REG_TOP_BAND:    gains_next[0] = wval;
                sfsfeq_pkg::REG_BAND_ONE:    gains_next[1] = wval;
                sfsfeq_pkg::REG_BAND_TWO:    gains_next[2] = wval;
                sfsfeq_pkg::REG_BAND_THREE:  gains_next[3] = wval;
                sfsfeq_pkg::REG_BAND_FOUR:   gains_next[4] = wval;
                sfsfeq_pkg::REG_BOTTOM_BAND: gains_next[5] = wval;
                default:                     gains_next = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sfsfeq_pkg::REG_TOP_BAND:    rval = gains_reg[0];
            sfsfeq_pkg::REG_BAND_ONE:    rval = gains_reg[1];
            sfsfeq_pkg::REG_BAND_TWO:    rval = gains_reg[2];
            sfsfeq_pkg::REG_BAND_THREE:  rval = gains_reg[3];
            sfsfeq_pkg::REG_BAND_FOUR:   rval = gains_reg[4];
            sfsfeq_pkg::REG_BOTTOM_BAND: rval = gains_reg[5];
            default:                     rval = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= {sfsfeq_pkg::NUM_GAINS{sfsfeq_pkg::GAIN_RESET}};
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign prdata = {{(sfsfeq_pkg::PDATA_W - sfsfeq_pkg::GAIN_W){1'b0}}, rval};
    assign pready = 1'b1;
    assign gains = gains_reg;

endmodule

>>> verif/stereo_five_band_slew_filter_eq_core_tb.sv
// self-checking testbench for stereo_five_band_slew_filter_eq_core: directed table plus
// random phases, each pair checked against its table value if known, else a bit-exact
// equalizer predictor in this file; depends on sfsfeq_pkg and the core rtl
module stereo_five_band_slew_filter_eq_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfsfeq_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 800;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS = 75;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_SHOWN = 10;
    localparam int GAIN_MAX = 32767;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint SAMPLE_MAX = 64'sd8388607;
    localparam longint SAMPLE_MIN = -64'sd8388608;

    typedef enum logic [1:0] {
        PROF_UNITY,
        PROF_MUTE,
        PROF_FULL,
        PROF_SKEW
    } gain_profile_t;

    typedef struct packed {
        gain_profile_t              profile;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want_left;
        logic signed [SAMPLE_W-1:0] want_right;
    } eq_row_t;

    // unity gains telescope back to the input, zero gains give silence,
    // full gains double the input so the extremes clip
    localparam eq_row_t EQ_ROWS [24] = '{
        '{PROF_UNITY, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{PROF_UNITY, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
        '{PROF_UNITY, 24'sh800000, 24'sh7FFFFF, 1'b1, 24'sh800000, 24'sh7FFFFF},
        '{PROF_UNITY, 24'sd1, -24'sd1, 1'b1, 24'sd1, -24'sd1},
        '{PROF_UNITY, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF},
        '{PROF_UNITY, 24'sh800000, 24'sh800000, 1'b1, 24'sh800000, 24'sh800000},
        '{PROF_UNITY, 24'sh555555, 24'shAAAAAA, 1'b1, 24'sh555555, 24'shAAAAAA},
        '{PROF_UNITY, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{PROF_UNITY, 24'sd12345, -24'sd54321, 1'b1, 24'sd12345, -24'sd54321},
        '{PROF_MUTE, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sd0, 24'sd0},
        '{PROF_MUTE, 24'sh800000, 24'sh7FFFFF, 1'b1, 24'sd0, 24'sd0},
        '{PROF_MUTE, 24'sd100000, -24'sd100000, 1'b1, 24'sd0, 24'sd0},
        '{PROF_MUTE, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
        '{PROF_FULL, 24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
        '{PROF_FULL, 24'sh800000, 24'sh7FFFFF, 1'b1, 24'sh800000, 24'sh7FFFFF},
        '{PROF_FULL, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{PROF_FULL, 24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
        '{PROF_FULL, 24'sd4194304, -24'sd4194304, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, 24'sh800000, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, 24'sd7000000, -24'sd7000000, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, -24'sd1, 24'sd1, 1'b0, 24'sd0, 24'sd0},
        '{PROF_SKEW, 24'sh7FFFFF, 24'sh800000, 1'b0, 24'sd0, 24'sd0}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    in_t                in_data;
    logic               out_valid;
    logic               out_ready;
    out_t               out_data;

    // predictor state: section pos/slew words per pass, section and channel
    longint pos_mem [PASSES][NUM_SECTIONS][2];
    longint slew_mem [PASSES][NUM_SECTIONS][2];
    int     gain_shadow [NUM_GAINS];
    out_t   pending_pairs [$];
    int     fault_count;
    bit     calm;
    bit     long_hold;

    stereo_five_band_slew_filter_eq_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_fault(string msg);
        if (fault_count < MAX_SHOWN)
            $display("%s", msg);
        fault_count++;
    endfunction

    // add half then floor, i.e. round half toward plus infinity
    function automatic longint round_shift_up(longint p, int s);
        return (p + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint equalize_channel(longint x, int ch);
        longint low [NUM_SECTIONS];
        longint acc;
        longint prev;
        longint f;
        longint pos;
        longint slw;
        longint nslew;
        longint lp;
        for (int p = 0; p < PASSES; p++)
        begin
            prev = x;
            for (int s = 0; s < NUM_SECTIONS; s++)
            begin
                f = longint'(SECTION_COEF[s]);
                pos = pos_mem[p][s][ch];
                slw = slew_mem[p][s][ch];
                nslew = round_shift_up((prev - pos + slw) * f, 25);
                lp = round_shift_up(f * prev + ((64'sd1 << 24) - f) * (pos + slw), 24);
                lp = clip(lp, WORD_MIN, WORD_MAX);
                pos_mem[p][s][ch] = lp;
                slew_mem[p][s][ch] = clip(nslew, WORD_MIN, WORD_MAX);
                low[s] = lp;
                prev = lp;
            end
            acc = (x - low[0]) * gain_shadow[0];
            for (int s = 0; s + 1 < NUM_SECTIONS; s++)
                acc += (low[s] - low[s + 1]) * gain_shadow[s + 1];
            acc += low[NUM_SECTIONS - 1] * gain_shadow[NUM_GAINS - 1];
            x = clip(round_shift_up(acc, 14), WORD_MIN, WORD_MAX);
        end
        return x;
    endfunction

    function automatic out_t equalize_pair(in_t smp);
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        out_t res;
        l = smp.left_sample;
        r = smp.right_sample;
        res.left_out = 24'(clip(equalize_channel(longint'(l), 0), SAMPLE_MIN, SAMPLE_MAX));
        res.right_out = 24'(clip(equalize_channel(longint'(r), 1), SAMPLE_MIN, SAMPLE_MAX));
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] prev);
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2, 3: return 24'(int'($urandom_range(0, 511)) - 256);
            4: return prev;
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return GAIN_MAX;
            2: return int'(GAIN_RESET);
            default: return int'($urandom_range(0, GAIN_MAX));
        endcase
    endfunction

    // all tasks below start and return at a falling edge
    task automatic apb_write(int idx, logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx < NUM_GAINS)
            gain_shadow[idx] = int'(val[GAIN_W-1:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check(int idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(gain_shadow[idx]))
            note_fault($sformatf("gain readback %0d: expected %0d, got %0d",
                                 idx, gain_shadow[idx], prdata));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // junk in the upper data bits, two writes to unmapped indexes, then read back
    task automatic load_gains(input int g [NUM_GAINS]);
        for (int i = REG_TOP_BAND; i <= REG_BOTTOM_BAND; i++)
            apb_write(i, ($urandom() & ~32'h7FFF) | PDATA_W'(g[i]));
        apb_write(NUM_GAINS, $urandom());
        apb_write(NUM_GAINS + 1, $urandom());
        for (int i = REG_TOP_BAND; i <= REG_BOTTOM_BAND; i++)
            apb_check(i);
    endtask

    task automatic send_item(in_t smp, bit known, out_t want);
        out_t predicted;
        in_valid <= 1'b1;
        in_data <= smp;
        do @(posedge clk); while (!(in_valid && in_ready));
        predicted = equalize_pair(smp);
        pending_pairs.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // receiver: random back-pressure bursts, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
                note_fault($sformatf("unexpected result: left %0d right %0d",
                                     out_data.left_out, out_data.right_out));
            else
            begin
                want = pending_pairs.pop_front();
                if (out_data.left_out !== want.left_out || out_data.right_out !== want.right_out)
                    note_fault($sformatf("mismatch: expected left %0d right %0d, got left %0d right %0d",
                                         want.left_out, want.right_out,
                                         out_data.left_out, out_data.right_out));
            end
        end
    end

    initial
    begin
        wait (rst_n);
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        eq_row_t       row;
        gain_profile_t cur;
        in_t           smp;
        out_t          want;
        int            g [NUM_GAINS];
        logic signed [SAMPLE_W-1:0] prev_l;
        logic signed [SAMPLE_W-1:0] prev_r;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        calm = 1'b0;
        long_hold = 1'b0;
        fault_count = 0;
        prev_l = '0;
        prev_r = '0;
        for (int p = 0; p < PASSES; p++)
            for (int s = 0; s < NUM_SECTIONS; s++)
                for (int c = 0; c < 2; c++)
                begin
                    pos_mem[p][s][c] = 0;
                    slew_mem[p][s][c] = 0;
                end
        for (int i = 0; i < NUM_GAINS; i++)
            gain_shadow[i] = int'(GAIN_RESET);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the gain registers
        for (int i = REG_TOP_BAND; i <= REG_BOTTOM_BAND; i++)
            apb_check(i);

        cur = PROF_UNITY;
        for (int i = 0; i < $size(EQ_ROWS); i++)
        begin
            row = EQ_ROWS[i];
            if (row.profile != cur)
            begin
                in_valid <= 1'b0;
                drain();
                case (row.profile)
                    PROF_UNITY: g = '{default: int'(GAIN_RESET)};
                    PROF_MUTE:  g = '{default: 0};
                    PROF_FULL:  g = '{default: GAIN_MAX};
                    default:    g = '{GAIN_MAX, 0, int'(GAIN_RESET), 1, GAIN_MAX, 8000};
                endcase
                load_gains(g);
                cur = row.profile;
            end
            else
                maybe_gap();
            smp.left_sample = row.left;
            smp.right_sample = row.right;
            want.left_out = row.want_left;
            want.right_out = row.want_right;
            send_item(smp, row.known, want);
        end

        want = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            drain();
            for (int k = 0; k < NUM_GAINS; k++)
                g[k] = pick_gain();
            load_gains(g);
            calm = (ph == RANDOM_PHASES - 1);
            // stall the output long enough for the core to back up into its input
            if (ph == 1)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                maybe_gap();
                smp.left_sample = pick_sample(prev_l);
                smp.right_sample = pick_sample(prev_r);
                prev_l = smp.left_sample;
                prev_r = smp.right_sample;
                send_item(smp, 1'b0, want);
            end
        end

        in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_pairs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> stereo_five_band_slew_filter_eq_core.f
hdl/sfsfeq_pkg.sv
hdl/sfsfeq_ram.sv
hdl/sfsfeq_regs.sv
hdl/stereo_five_band_slew_filter_eq_core.sv
verif/stereo_five_band_slew_filter_eq_core_tb.sv
